/* design/gse_pkg.sv */
package gse_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(MAP_DEPTH);

  localparam int POS_W = 6;
  localparam int SIZE_W = 7;
  localparam int COST_W = 16;
  localparam int EST_W = 11;
  localparam int DIR_W = 3;

  localparam logic [SIZE_W-1:0] ROW_CAP = SIZE_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
  localparam logic [SIZE_W-1:0] COL_CAP = SIZE_W'((MAX_COLS < 64) ? MAX_COLS : 64);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

  localparam logic [COST_W-1:0] STRAIGHT_STEP = COST_W'(10);
  localparam logic [COST_W-1:0] DIAGONAL_STEP = COST_W'(14);
  localparam logic [DIR_W-1:0] LAST_DIR = DIR_W'(7);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EXPAND = 1'b1;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_TROW = 2'd2;
  localparam logic [1:0] REG_TCOL = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXPAND
  } gse_state_e;

  typedef enum logic [1:0] {
    D_ZERO,
    D_DEC,
    D_INC
  } gse_delta_e;

  typedef struct packed {
    logic              cmd;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              cell_free;
    logic [COST_W-1:0] pcost;
  } gse_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [POS_W-1:0]  trow;
    logic [POS_W-1:0]  tcol;
  } gse_cfg_t;

  typedef struct packed {
    logic [DIR_W-1:0]  dir;
    logic              inb;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [COST_W-1:0] pcost;
  } gse_issue_t;

  typedef struct packed {
    logic              neg;
    logic [SIZE_W-1:0] val;
  } gse_step_t;

  function automatic gse_delta_e row_delta(input logic [DIR_W-1:0] dir);
    gse_delta_e d;
    case (dir)
      3'd0, 3'd4, 3'd6: d = D_DEC;
      3'd1, 3'd5, 3'd7: d = D_INC;
      default:          d = D_ZERO;
    endcase
    return d;
  endfunction

  function automatic gse_delta_e col_delta(input logic [DIR_W-1:0] dir);
    gse_delta_e d;
    case (dir)
      3'd2, 3'd4, 3'd5: d = D_DEC;
      3'd3, 3'd6, 3'd7: d = D_INC;
      default:          d = D_ZERO;
    endcase
    return d;
  endfunction

  function automatic gse_step_t step_pos(input logic [POS_W-1:0] pos, input gse_delta_e d);
    gse_step_t s;
    s.neg = 1'b0;
    s.val = {1'b0, pos};
    case (d)
      D_DEC: begin
        s.neg = (pos == '0);
        s.val = {1'b0, pos} - SIZE_W'(1);
      end
      D_INC:   s.val = {1'b0, pos} + SIZE_W'(1);
      default: s.val = {1'b0, pos};
    endcase
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
  endfunction

endpackage

/* design/gse_ram.sv */
module gse_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gse_seq.sv */
module gse_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  output logic                      item_ready_o,
  input  gse_pkg::gse_item_t        item_i,
  input  gse_pkg::gse_cfg_t         cfg_i,
  output logic                      issue_valid_o,
  input  logic                      issue_ready_i,
  output gse_pkg::gse_issue_t       issue_o,
  output logic                      ram_we_o,
  output logic [gse_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic                      ram_wdata_o,
  output logic                      ram_re_o,
  output logic [gse_pkg::ADDR_W-1:0] ram_raddr_o
);
  import gse_pkg::*;

  gse_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [DIR_W-1:0]  dir_q, dir_d;
  logic [POS_W-1:0]  row_q, row_d;
  logic [POS_W-1:0]  col_q, col_d;
  logic [COST_W-1:0] pcost_q, pcost_d;

  logic              item_fire;
  logic              issue_fire;
  logic              wr_in_range;
  gse_step_t         nr, nc;
  logic [SIZE_W-1:0] row_bound, col_bound;

  assign item_fire = item_valid_i && item_ready_o;
  assign issue_fire = issue_valid_o && issue_ready_i;
  assign wr_in_range = (32'(item_i.row) < MAX_ROWS) && (32'(item_i.col) < MAX_COLS);

  // neighbor position and bound check
  assign nr = step_pos(row_q, row_delta(dir_q));
  assign nc = step_pos(col_q, col_delta(dir_q));
  assign row_bound = (cfg_i.rows < ROW_CAP) ? cfg_i.rows : ROW_CAP;
  assign col_bound = (cfg_i.cols < COL_CAP) ? cfg_i.cols : COL_CAP;

  always_comb begin
    issue_o.dir = dir_q;
    issue_o.inb = !nr.neg && !nc.neg && (nr.val < row_bound) && (nc.val < col_bound);
    issue_o.row = nr.val[POS_W-1:0];
    issue_o.col = nc.val[POS_W-1:0];
    issue_o.pcost = pcost_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_fire && item_i.cmd == CMD_EXPAND) state_d = ST_EXPAND;
      end
      ST_EXPAND: begin
        if (issue_fire && dir_q == LAST_DIR) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    item_ready_o = 1'b0;
    issue_valid_o = 1'b0;
    ram_we_o = 1'b0;
    ram_waddr_o = cell_addr(item_i.row, item_i.col);
    ram_wdata_o = item_i.cell_free;
    ram_re_o = 1'b0;
    ram_raddr_o = cell_addr(issue_o.row, issue_o.col);
    case (state_q)
      ST_CLEAR: begin
        ram_we_o = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = 1'b0;
      end
      ST_IDLE: begin
        item_ready_o = 1'b1;
        ram_we_o = item_valid_i && item_i.cmd == CMD_WRITE && wr_in_range;
      end
      ST_EXPAND: begin
        issue_valid_o = 1'b1;
        ram_re_o = issue_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    clr_d = clr_q;
    dir_d = dir_q;
    row_d = row_q;
    col_d = col_q;
    pcost_d = pcost_q;
    if (state_q == ST_CLEAR) clr_d = clr_q + ADDR_W'(1);
    if (item_fire) begin
      dir_d = '0;
      row_d = item_i.row;
      col_d = item_i.col;
      pcost_d = item_i.pcost;
    end else if (issue_fire) begin
      dir_d = dir_q + DIR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      dir_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      dir_q <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    pcost_q <= pcost_d;
  end

endmodule

/* design/gse_calc.sv */
module gse_calc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        issue_valid_i,
  output logic                        issue_ready_o,
  input  gse_pkg::gse_issue_t         issue_i,
  input  gse_pkg::gse_cfg_t           cfg_i,
  input  logic                        ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gse_pkg::DIR_W-1:0]   move_dir_o,
  output logic                        succ_valid_o,
  output logic [gse_pkg::POS_W-1:0]   succ_row_o,
  output logic [gse_pkg::POS_W-1:0]   succ_col_o,
  output logic [gse_pkg::COST_W-1:0]  succ_cost_o,
  output logic [gse_pkg::EST_W-1:0]   succ_estimate_o,
  output logic                        last_o
);
  import gse_pkg::*;

  typedef struct packed {
    logic [DIR_W-1:0]  dir;
    logic              inb;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [COST_W-1:0] cost;
    logic [EST_W-1:0]  est;
  } calc_t;

  logic              s1_valid_q, s1_valid_d;
  calc_t             s1_q, s1_d;
  logic              out_valid_q, out_valid_d;
  logic              ok;
  logic              s1_adv;
  logic              issue_fire;
  logic [COST_W:0]   cost_sum;
  logic [POS_W-1:0]  drow, dcol;
  logic [POS_W:0]    man_dist;

  logic [DIR_W-1:0]  dir_q;
  logic              val_q;
  logic [POS_W-1:0]  row_q, col_q;
  logic [COST_W-1:0] cost_q;
  logic [EST_W-1:0]  est_q;

  assign issue_fire = issue_valid_i && issue_ready_o;
  assign s1_adv = s1_valid_q && (!out_valid_q || out_ready_i);
  assign issue_ready_o = !s1_valid_q || s1_adv;

  // cost and estimate while the map bit is read
  always_comb begin
    cost_sum = {1'b0, issue_i.pcost} +
               {1'b0, (issue_i.dir[2] ? DIAGONAL_STEP : STRAIGHT_STEP)};
    drow = (issue_i.row >= cfg_i.trow) ? issue_i.row - cfg_i.trow : cfg_i.trow - issue_i.row;
    dcol = (issue_i.col >= cfg_i.tcol) ? issue_i.col - cfg_i.tcol : cfg_i.tcol - issue_i.col;
    man_dist = {1'b0, drow} + {1'b0, dcol};
    s1_d.dir = issue_i.dir;
    s1_d.inb = issue_i.inb;
    s1_d.row = issue_i.row;
    s1_d.col = issue_i.col;
    s1_d.cost = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
    s1_d.est = (EST_W'(man_dist) << 3) + (EST_W'(man_dist) << 1);
  end

  assign ok = s1_q.inb && ram_rdata_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (issue_fire) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_adv) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_fire) s1_q <= s1_d;
    if (s1_adv) begin
      dir_q <= s1_q.dir;
      val_q <= ok;
      row_q <= ok ? s1_q.row : '0;
      col_q <= ok ? s1_q.col : '0;
      cost_q <= ok ? s1_q.cost : '0;
      est_q <= ok ? s1_q.est : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign move_dir_o = dir_q;
  assign succ_valid_o = val_q;
  assign succ_row_o = row_q;
  assign succ_col_o = col_q;
  assign succ_cost_o = cost_q;
  assign succ_estimate_o = est_q;
  assign last_o = (dir_q == LAST_DIR);

endmodule

/* design/grid_successor_expansion.sv */
// Grid successor expansion: a one-bit free/blocked map of MAX_ROWS x MAX_COLS cells held in a
// synchronous memory. After reset the block sweeps the map to blocked, one cell a cycle, with
// s_axis_tready_o low; APB writes are taken during it. A write word (tuser 0) writes its
// cell_free bit into the map. An expand word (tuser 1) makes one map read per neighbor through
// the single read port; its eight result words (up, down, left, right, up-left, down-left,
// up-right, down-right) leave one per cycle while m_axis_tready_i is high, registered behind
// the reads, the eighth with tlast. The sizes and target registers must be written while the
// block is idle.
module grid_successor_expansion (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // row_index, col_index, cell_free, parent_cost
  input  logic        s_axis_tuser_i,  // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // succ_valid, succ_row, succ_col, succ_cost, succ_estimate
  output logic [39:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,  // move_dir
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gse_pkg::*;

  gse_cfg_t          cfg_q, cfg_d;
  gse_item_t         item;
  gse_issue_t        issue;
  logic              cfg_wr;
  logic              issue_valid, issue_ready;
  logic              ram_we, ram_wdata, ram_re, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic              succ_valid;
  logic [POS_W-1:0]  succ_row, succ_col;
  logic [COST_W-1:0] succ_cost;
  logic [EST_W-1:0]  succ_est;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS: cfg_d.rows = pwdata[SIZE_W-1:0];
        REG_COLS: cfg_d.cols = pwdata[SIZE_W-1:0];
        REG_TROW: cfg_d.trow = pwdata[POS_W-1:0];
        REG_TCOL: cfg_d.tcol = pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS: prdata = 32'(cfg_q.rows);
      REG_COLS: prdata = 32'(cfg_q.cols);
      REG_TROW: prdata = 32'(cfg_q.trow);
      REG_TCOL: prdata = 32'(cfg_q.tcol);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows <= SIZE_W'(64);
      cfg_q.cols <= SIZE_W'(64);
      cfg_q.trow <= '0;
      cfg_q.tcol <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item.cmd = s_axis_tuser_i;
  assign item.row = s_axis_tdata_i[5:0];
  assign item.col = s_axis_tdata_i[11:6];
  assign item.cell_free = s_axis_tdata_i[12];
  assign item.pcost = s_axis_tdata_i[28:13];

  gse_seq u_seq (
    .clk_i,
    .rst_ni,
    .item_valid_i  (s_axis_tvalid_i),
    .item_ready_o  (s_axis_tready_o),
    .item_i        (item),
    .cfg_i         (cfg_q),
    .issue_valid_o (issue_valid),
    .issue_ready_i (issue_ready),
    .issue_o       (issue),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  gse_ram #(
    .Width (1),
    .Depth (MAP_DEPTH)
  ) u_map (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gse_calc u_calc (
    .clk_i,
    .rst_ni,
    .issue_valid_i   (issue_valid),
    .issue_ready_o   (issue_ready),
    .issue_i         (issue),
    .cfg_i           (cfg_q),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .move_dir_o      (m_axis_tuser_o),
    .succ_valid_o    (succ_valid),
    .succ_row_o      (succ_row),
    .succ_col_o      (succ_col),
    .succ_cost_o     (succ_cost),
    .succ_estimate_o (succ_est),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {succ_est, succ_cost, succ_col, succ_row, succ_valid};

endmodule

/* design/gse_checker.sv */
module gse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // tlast marks exactly the down-right word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == 3'd7)))
    else $error("tlast does not match the last direction");

  // a rejected neighbor carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[39:1] == 39'd0))
    else $error("invalid successor with nonzero fields");

  // a valid successor costs at least one straight step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> (m_axis_tdata_o[28:13] >= 16'd10))
    else $error("successor cost below step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result word changed");

endmodule

bind grid_successor_expansion gse_checker u_gse_checker (.*);
